/* rtl/core/lidr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lidr_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned OPC_W  = 3;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned ERR_W  = 2;

    // Default list capacity and the pointer width that covers its whole range (2 to 64).
    localparam int unsigned CAPACITY_DEF = 32;
    localparam int unsigned PTR_W        = 7;

    // Request opcodes.
    localparam logic [OPC_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OPC_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OPC_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OPC_W-1:0] OP_MARK    = 3'd3;
    localparam logic [OPC_W-1:0] OP_COMMIT  = 3'd4;
    localparam logic [OPC_W-1:0] OP_REVERSE = 3'd5;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_POS  = 2'd2;

    // Commands broadcast to every cell of the row.
    localparam int unsigned CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 3'd1;
    localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd2;
    localparam logic [CELL_OP_W-1:0] CELL_DELETE = 3'd3;
    localparam logic [CELL_OP_W-1:0] CELL_ROTATE = 3'd4;
    localparam logic [CELL_OP_W-1:0] CELL_MARK   = 3'd5;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] item_value;
        logic [POS_W-1:0]        position;
    } request_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] entry_value;
        logic [IDX_W-1:0]        entry_index;
        logic                    last_entry;
        logic                    list_empty;
        logic [ERR_W-1:0]        error_code;
    } result_t;

    typedef struct packed {
        logic [CELL_OP_W-1:0]    op;
        logic [PTR_W-1:0]        ptr;
        logic signed [VAL_W-1:0] data;
        logic                    keep;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/lidr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One list slot: holds an entry and its delete mark, and trades them with its neighbors.
module lidr_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  lidr_pkg::cell_cmd_t              cmd,
    input  wire signed [lidr_pkg::VAL_W-1:0] left_value,
    input  wire signed [lidr_pkg::VAL_W-1:0] right_value,
    input  wire                              right_mark,
    output logic signed [lidr_pkg::VAL_W-1:0] value,
    output logic                             mark
);
    import lidr_pkg::*;

    localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(INDEX);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    mark_reg;
    logic                    mark_next;
    logic                    at_ptr;
    logic                    above_ptr;

    assign at_ptr    = (cmd.ptr == MY_IDX);
    assign above_ptr = (MY_IDX > cmd.ptr);

    // Slot update for the broadcast command.
    always_comb
    begin
        value_next = value_reg;
        mark_next  = mark_reg;
        unique case (cmd.op)
            CELL_WRITE:
            begin
                if (at_ptr)
                begin
                    value_next = cmd.data;
                    mark_next  = 1'b0;
                end
            end
            CELL_INSERT:
            begin
                // Slots past the insert point move up by one; all marks drop.
                if (above_ptr)
                    value_next = left_value;
                else if (at_ptr)
                    value_next = cmd.data;
                mark_next = 1'b0;
            end
            CELL_DELETE:
            begin
                if (above_ptr || at_ptr)
                    value_next = right_value;
                mark_next = 1'b0;
            end
            CELL_ROTATE:
            begin
                // The head leaves; slots below the pointer move down and the
                // pointer slot takes the head back when it is kept.
                if (at_ptr && cmd.keep)
                begin
                    value_next = cmd.data;
                    mark_next  = 1'b0;
                end
                else if (!above_ptr)
                begin
                    value_next = right_value;
                    mark_next  = right_mark;
                end
            end
            CELL_MARK:
            begin
                if (at_ptr)
                    mark_next = 1'b1;
            end
            default:
            begin
                value_next = value_reg;
                mark_next  = mark_reg;
            end
        endcase
    end

    // Entry storage needs no reset; only the marks are cleared.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_reg <= 1'b0;
        else
            mark_reg <= mark_next;
    end

    assign value = value_reg;
    assign mark  = mark_reg;

endmodule

`default_nettype wire

/* rtl/core/list_insert_delete_reverse.sv */
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries, held in a row of cells that
// shift data to their neighbors. An item is taken when start is high and busy is low.
// Load and mark give no result. Insert and delete edit the row in the cycle the
// item is taken, then list the N entries of the new list, one result per cycle,
// with busy high throughout (a delete that empties the list gives the empty-list
// result instead). Commit and reverse first rotate the N entries once through the
// head cell, one entry per cycle, then list the M entries that remain (M = N for
// reverse), or give the empty-list result when none remain; busy stays high
// throughout. An error answer is a single result and does not raise busy.
// Results are registered, each shown for exactly one cycle with strobe high; the
// receiver has to take every one as it comes, as the block cannot hold them back.
// The listing rate of one entry per cycle is set by the rotation of the cell row
// through its head cell.
module list_insert_delete_reverse #(
    parameter int unsigned CAPACITY = lidr_pkg::CAPACITY_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  lidr_pkg::request_t   req,
    output logic                 busy,
    output logic                 strobe,
    output lidr_pkg::result_t    result
);
    import lidr_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROT  = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic             is_rev_reg;
    logic             is_rev_next;
    logic             strobe_reg;
    logic             strobe_next;
    result_t          result_reg;
    result_t          result_next;

    cell_cmd_t               cmd;
    logic signed [VAL_W-1:0] cell_value [CAPACITY];
    logic                    cell_mark  [CAPACITY];
    logic signed [VAL_W-1:0] head_value;
    logic                    head_mark;
    logic [PTR_W-1:0]        count_ptr;
    logic [PTR_W-1:0]        pos_ptr;
    logic                    last_step;

    // Row of cells, each seeing its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_v;
        logic signed [VAL_W-1:0] right_v;
        logic                    right_m;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_left
            assign left_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
            assign right_m = 1'b0;
        end
        else
        begin : g_mid_right
            assign right_v = cell_value[i+1];
            assign right_m = cell_mark[i+1];
        end

        lidr_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_value  (left_v),
            .right_value (right_v),
            .right_mark  (right_m),
            .value       (cell_value[i]),
            .mark        (cell_mark[i])
        );
    end

    assign head_value = cell_value[0];
    assign head_mark  = cell_mark[0];
    assign count_ptr  = PTR_W'(count_reg);
    assign pos_ptr    = PTR_W'(req.position);
    assign last_step  = (step_reg == count_reg - CNT_W'(1));

    // Sequencer: decodes items, drives the row and forms the results.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        step_next   = step_reg;
        is_rev_next = is_rev_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        cmd.op      = CELL_HOLD;
        cmd.ptr     = '0;
        cmd.data    = req.item_value;
        cmd.keep    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.opcode) inside
                        OP_LOAD:
                        begin
                            if (count_reg != CNT_W'(CAPACITY))
                            begin
                                cmd.op     = CELL_WRITE;
                                cmd.ptr    = count_ptr;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                strobe_next = 1'b1;
                                result_next = '{entry_value: '0, entry_index: '0,
                                                last_entry: 1'b1, list_empty: 1'b0,
                                                error_code: ERR_FULL};
                            end
                            else if (pos_ptr > count_ptr)
                            begin
                                strobe_next = 1'b1;
                                result_next = '{entry_value: '0, entry_index: '0,
                                                last_entry: 1'b1, list_empty: 1'b0,
                                                error_code: ERR_POS};
                            end
                            else
                            begin
                                cmd.op     = CELL_INSERT;
                                cmd.ptr    = pos_ptr;
                                count_next = count_reg + CNT_W'(1);
                                step_next  = '0;
                                state_next = ST_LIST;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_ptr >= count_ptr)
                            begin
                                strobe_next = 1'b1;
                                result_next = '{entry_value: '0, entry_index: '0,
                                                last_entry: 1'b1, list_empty: 1'b0,
                                                error_code: ERR_POS};
                            end
                            else
                            begin
                                cmd.op     = CELL_DELETE;
                                cmd.ptr    = pos_ptr;
                                count_next = count_reg - CNT_W'(1);
                                step_next  = '0;
                                state_next = ST_LIST;
                            end
                        end
                        OP_MARK:
                        begin
                            if (pos_ptr < count_ptr)
                            begin
                                cmd.op  = CELL_MARK;
                                cmd.ptr = pos_ptr;
                            end
                        end
                        OP_COMMIT, OP_REVERSE:
                        begin
                            step_next   = '0;
                            n_next      = count_reg;
                            is_rev_next = (req.opcode == OP_REVERSE);
                            if (count_reg == '0)
                                state_next = ST_LIST;
                            else
                                state_next = ST_ROT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROT:
            begin
                // Each step pops the head and places it back into the row, or drops it in a commit when it is marked.
                cmd.op   = CELL_ROTATE;
                cmd.data = head_value;
                if (is_rev_reg)
                begin
                    cmd.ptr  = PTR_W'(n_reg) - PTR_W'(step_reg) - PTR_W'(1);
                    cmd.keep = 1'b1;
                end
                else
                begin
                    cmd.ptr  = count_ptr - PTR_W'(1);
                    cmd.keep = !head_mark;
                    if (head_mark)
                        count_next = count_reg - CNT_W'(1);
                end
                step_next = step_reg + CNT_W'(1);
                if (step_reg == n_reg - CNT_W'(1))
                begin
                    step_next  = '0;
                    state_next = ST_LIST;
                end
            end
            ST_LIST:
            begin
                strobe_next = 1'b1;
                if (count_reg == '0)
                begin
                    result_next = '{entry_value: '0, entry_index: '0,
                                    last_entry: 1'b1, list_empty: 1'b1,
                                    error_code: ERR_NONE};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // Show the head and rotate it to the tail.
                    cmd.op      = CELL_ROTATE;
                    cmd.data    = head_value;
                    cmd.ptr     = count_ptr - PTR_W'(1);
                    cmd.keep    = 1'b1;
                    result_next = '{entry_value: head_value,
                                    entry_index: IDX_W'(step_reg),
                                    last_entry: last_step, list_empty: 1'b0,
                                    error_code: ERR_NONE};
                    step_next   = step_reg + CNT_W'(1);
                    if (last_step)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            n_reg      <= '0;
            step_reg   <= '0;
            is_rev_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            step_reg   <= step_next;
            is_rev_reg <= is_rev_next;
            strobe_reg <= strobe_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/lidr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the result stream.
module lidr_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                start,
    input lidr_pkg::request_t req,
    input wire                busy,
    input wire                strobe,
    input lidr_pkg::result_t  result
);
    import lidr_pkg::*;

    // An empty-list item always closes its answer.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.list_empty |-> result.last_entry)
        else $error("empty-list item without last marker");

    // An error answer is a single bare item.
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.error_code != ERR_NONE) |->
            result.last_entry && !result.list_empty && (result.entry_value == '0))
        else $error("malformed error item");

    // A listing runs without gaps and with rising positions.
    a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_entry |=>
            strobe && (result.entry_index == IDX_W'($past(result.entry_index) + 1'b1)))
        else $error("listing broken or out of order");

    // A load never produces an item.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.opcode == OP_LOAD) |=> !strobe)
        else $error("item produced after a load");

endmodule

bind list_insert_delete_reverse lidr_checker u_lidr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

/* tb/list_insert_delete_reverse_tb.sv */
`timescale 1ns / 1ps

module list_insert_delete_reverse_tb;

    import lidr_pkg::*;

    localparam int unsigned CAPACITY    = CAPACITY_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 408;

    // Opcodes that the block has to ignore.
    localparam logic [OPC_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct {
        request_t    req;
        int unsigned reps;
        bit          typed;
        result_t     want;
    } step_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t req = '0;
    logic     busy;
    logic     strobe;
    result_t  result;

    // Shadow copy of the list, updated as each item is accepted.
    logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
    int unsigned             shadow_len = 0;
    bit                      shadow_marks [CAPACITY];
    result_t                 edit_answer [$];

    // Entries still due from the block, oldest first.
    result_t pending_entries [$];

    step_row_t   plan [$];
    int unsigned failures = 0;
    int unsigned cycle_count = 0;
    int unsigned items_accepted = 0;
    int unsigned items_effective = 0;
    int unsigned results_checked = 0;
    int unsigned error_answers = 0;
    int unsigned empty_answers = 0;
    bit          quiet_stretch = 1'b0;

    list_insert_delete_reverse #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .strobe(strobe),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic request_t request_of(logic [OPC_W-1:0] op, logic signed [VAL_W-1:0] v,
                                            logic [POS_W-1:0] p);
        request_t r;
        r.opcode     = op;
        r.item_value = v;
        r.position   = p;
        return r;
    endfunction

    function automatic result_t answer_of(logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] idx,
                                          logic last, logic empty, logic [ERR_W-1:0] err);
        result_t a;
        a.entry_value = v;
        a.entry_index = idx;
        a.last_entry  = last;
        a.list_empty  = empty;
        a.error_code  = err;
        return a;
    endfunction

    // Append one row to the directed plan.
    function automatic void plan_row(logic [OPC_W-1:0] op, logic signed [VAL_W-1:0] v,
                                     logic [POS_W-1:0] p, int unsigned reps, bit typed,
                                     result_t want);
        step_row_t s;
        s.req   = request_of(op, v, p);
        s.reps  = reps;
        s.typed = typed;
        s.want  = want;
        plan.insert(plan.size(), s);
    endfunction

    // Add one result to the answer of the current item.
    function automatic void add_answer(result_t a);
        edit_answer.insert(edit_answer.size(), a);
    endfunction

    // Add one result to the entries due from the block.
    function automatic void expect_result(result_t a);
        pending_entries.insert(pending_entries.size(), a);
    endfunction

    // Queue the full listing of the shadow list, or the empty marker.
    function automatic void list_shadow();
        if (shadow_len == 0)
        begin
            add_answer(answer_of('0, '0, 1'b1, 1'b1, ERR_NONE));
        end
        else
        begin
            for (int unsigned i = 0; i < shadow_len; i++)
            begin
                add_answer(answer_of(shadow_vals[i], i[IDX_W-1:0],
                                     i + 1 == shadow_len, 1'b0, ERR_NONE));
            end
        end
    endfunction

    function automatic void clear_shadow_marks();
        foreach (shadow_marks[i])
        begin
            shadow_marks[i] = 1'b0;
        end
    endfunction

    // Apply one item to the shadow list and leave its answer in edit_answer.
    // Returns 1 when the item had any effect or answer.
    function automatic bit apply_edit(request_t r);
        int unsigned        pos;
        int unsigned        w;
        logic signed [31:0] t;
        pos = 32'(r.position);
        edit_answer.delete();
        case (r.opcode)
            OP_LOAD:
            begin
                if (shadow_len >= CAPACITY)
                begin
                    return 1'b0;
                end
                shadow_vals[shadow_len] = r.item_value;
                shadow_len++;
            end
            OP_INSERT:
            begin
                // A full list is reported before the position is looked at.
                if (shadow_len >= CAPACITY)
                begin
                    add_answer(answer_of('0, '0, 1'b1, 1'b0, ERR_FULL));
                end
                else if (pos > shadow_len)
                begin
                    add_answer(answer_of('0, '0, 1'b1, 1'b0, ERR_POS));
                end
                else
                begin
                    for (int unsigned i = shadow_len; i > pos; i--)
                    begin
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_vals[pos] = r.item_value;
                    shadow_len++;
                    clear_shadow_marks();
                    list_shadow();
                end
            end
            OP_DELETE:
            begin
                if (pos >= shadow_len)
                begin
                    add_answer(answer_of('0, '0, 1'b1, 1'b0, ERR_POS));
                end
                else
                begin
                    for (int unsigned i = pos; i + 1 < shadow_len; i++)
                    begin
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_len--;
                    clear_shadow_marks();
                    list_shadow();
                end
            end
            OP_MARK:
            begin
                // Out-of-range and repeated marks leave nothing behind.
                if (pos >= shadow_len || shadow_marks[pos])
                begin
                    return 1'b0;
                end
                shadow_marks[pos] = 1'b1;
            end
            OP_COMMIT:
            begin
                w = 0;
                for (int unsigned i = 0; i < shadow_len; i++)
                begin
                    if (!shadow_marks[i])
                    begin
                        shadow_vals[w] = shadow_vals[i];
                        w++;
                    end
                end
                shadow_len = w;
                clear_shadow_marks();
                list_shadow();
            end
            OP_REVERSE:
            begin
                for (int unsigned i = 0; i < shadow_len / 2; i++)
                begin
                    t = shadow_vals[i];
                    shadow_vals[i] = shadow_vals[shadow_len-1-i];
                    shadow_vals[shadow_len-1-i] = t;
                end
                clear_shadow_marks();
                list_shadow();
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Mostly no gap, some short ones, a few long ones, and stretches without any.
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(99);
        if (quiet_stretch || pick < 55)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 5);
    endfunction

    // Mostly valid edits sized to the current list, some bad positions and some noise.
    function automatic request_t next_random_req();
        request_t    r;
        int unsigned pick;
        int unsigned op_pick;
        bit          grow;
        pick    = $urandom_range(99);
        op_pick = $urandom_range(99);
        grow    = shadow_len < 20;
        r.item_value = $urandom;
        if (pick < 3)
        begin
            r.opcode   = OPC_W'($urandom_range(7));
            r.position = POS_W'($urandom_range(63));
        end
        else if (pick < 9)
        begin
            case (op_pick % 3)
                0:       r.opcode = OP_INSERT;
                1:       r.opcode = OP_DELETE;
                default: r.opcode = OP_MARK;
            endcase
            r.position = (r.opcode == OP_INSERT) ? POS_W'($urandom_range(63, shadow_len + 1))
                                                 : POS_W'($urandom_range(63, shadow_len));
        end
        else
        begin
            if (op_pick < (grow ? 35 : 10))
            begin
                r.opcode = OP_LOAD;
            end
            else if (op_pick < (grow ? 55 : 22))
            begin
                r.opcode = OP_INSERT;
            end
            else if (op_pick < (grow ? 68 : 50))
            begin
                r.opcode = OP_DELETE;
            end
            else if (op_pick < (grow ? 83 : 72))
            begin
                r.opcode = OP_MARK;
            end
            else if (op_pick < (grow ? 91 : 88))
            begin
                r.opcode = OP_COMMIT;
            end
            else
            begin
                r.opcode = OP_REVERSE;
            end
            if (r.opcode == OP_INSERT)
            begin
                r.position = POS_W'($urandom_range(shadow_len, 0));
            end
            else
            begin
                r.position = (shadow_len == 0) ? '0 : POS_W'($urandom_range(shadow_len - 1, 0));
            end
        end
        return r;
    endfunction

    // Offer one item, hold it until taken, then queue what it should produce.
    task automatic send_item(input request_t r, input bit typed, input result_t want,
                             input int unsigned gap);
        bit effective;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        effective = apply_edit(r);
        items_accepted++;
        if (effective)
        begin
            items_effective++;
        end
        if (typed)
        begin
            expect_result(want);
        end
        else
        begin
            foreach (edit_answer[i])
            begin
                expect_result(edit_answer[i]);
            end
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every entry due has come out.
    task automatic drain_pending();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_entries.size() != 0);
    endtask

    // Compare every strobed result with the oldest entry due.
    always @(posedge clk)
    begin
        result_t want;
        if (strobe)
        begin
            if (pending_entries.size() == 0)
            begin
                $error("unexpected result: value %0d index %0d last %0b empty %0b error %0d",
                       result.entry_value, result.entry_index, result.last_entry,
                       result.list_empty, result.error_code);
                failures++;
            end
            else
            begin
                want = pending_entries.pop_front();
                results_checked++;
                if (want.error_code != ERR_NONE)
                begin
                    error_answers++;
                end
                if (want.list_empty)
                begin
                    empty_answers++;
                end
                if (result.entry_value !== want.entry_value)
                begin
                    $error("entry_value: expected %0d, got %0d",
                           want.entry_value, result.entry_value);
                    failures++;
                end
                if (result.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, result.entry_index);
                    failures++;
                end
                if (result.last_entry !== want.last_entry)
                begin
                    $error("last_entry: expected %0b, got %0b",
                           want.last_entry, result.last_entry);
                    failures++;
                end
                if (result.list_empty !== want.list_empty)
                begin
                    $error("list_empty: expected %0b, got %0b",
                           want.list_empty, result.list_empty);
                    failures++;
                end
                if (result.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, result.error_code);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("list_insert_delete_reverse_tb: errors");
            $finish;
        end
    end

    initial
    begin
        result_t  empty_ans;
        result_t  pos_err;
        result_t  full_err;
        result_t  none;
        request_t r;
        int unsigned random_done;

        empty_ans = answer_of('0, '0, 1'b1, 1'b1, ERR_NONE);
        pos_err   = answer_of('0, '0, 1'b1, 1'b0, ERR_POS);
        full_err  = answer_of('0, '0, 1'b1, 1'b0, ERR_FULL);
        none      = '0;
        random_done = 0;

        // Directed part: empty list, extremes, marks, unused opcodes, full list.
        plan_row(OP_COMMIT, 32'sd0, 6'd0, 1, 1'b1, empty_ans);
        plan_row(OP_REVERSE, -32'sd1, 6'd63, 1, 1'b1, empty_ans);
        plan_row(OP_DELETE, 32'sd0, 6'd0, 1, 1'b1, pos_err);
        plan_row(OP_INSERT, 32'sd5, 6'd1, 1, 1'b1, pos_err);
        plan_row(OP_MARK, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_INSERT, 32'h8000_0000, 6'd0, 1, 1'b1,
                 answer_of(32'h8000_0000, '0, 1'b1, 1'b0, ERR_NONE));
        plan_row(OP_LOAD, 32'h7FFF_FFFF, 6'd63, 1, 1'b0, none);
        plan_row(OP_INSERT, -32'sd1, 6'd2, 1, 1'b0, none);
        plan_row(OP_INSERT, 32'sd0, 6'd1, 1, 1'b0, none);
        plan_row(OP_MARK, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_MARK, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_MARK, 32'sd0, 6'd3, 1, 1'b0, none);
        plan_row(OP_MARK, 32'sd0, 6'd4, 1, 1'b0, none);
        plan_row(OP_MARK, -32'sd1, 6'd63, 1, 1'b0, none);
        plan_row(OP_COMMIT, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_REVERSE, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_DELETE, 32'sd0, 6'd1, 1, 1'b0, none);
        plan_row(OP_DELETE, 32'sd0, 6'd0, 1, 1'b1, empty_ans);
        plan_row(OP_SPARE_A, -32'sd1, 6'd63, 1, 1'b0, none);
        plan_row(OP_SPARE_B, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_LOAD, 32'h5A5A_0000, 6'd0, CAPACITY, 1'b0, none);
        plan_row(OP_LOAD, 32'sd1, 6'd0, 1, 1'b0, none);
        plan_row(OP_INSERT, 32'sd1, 6'd63, 1, 1'b1, full_err);
        plan_row(OP_INSERT, 32'sd1, 6'd0, 1, 1'b1, full_err);
        plan_row(OP_DELETE, 32'sd0, 6'd32, 1, 1'b1, pos_err);
        plan_row(OP_MARK, 32'sd0, 6'd31, 1, 1'b0, none);
        plan_row(OP_MARK, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_COMMIT, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_DELETE, 32'sd0, 6'd63, 1, 1'b1, pos_err);
        plan_row(OP_REVERSE, 32'sd0, 6'd0, 1, 1'b0, none);
        plan_row(OP_DELETE, 32'sd0, 6'd29, 1, 1'b0, none);

        // Reset once at the start.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            for (int unsigned k = 0; k < plan[n].reps; k++)
            begin
                r = plan[n].req;
                r.item_value = r.item_value + k;
                send_item(r, plan[n].typed, plan[n].want, pick_gap());
            end
        end
        drain_pending();

        // Random part; the sender drains everything once more halfway through.
        while (random_done < RANDOM_ITEMS)
        begin
            if (random_done % 40 == 0)
            begin
                quiet_stretch = ($urandom_range(3) == 0);
            end
            r = next_random_req();
            send_item(r, 1'b0, none, pick_gap());
            random_done++;
            if (random_done == RANDOM_ITEMS / 2)
            begin
                drain_pending();
            end
        end

        // Let the last listing finish and catch any stray result.
        drain_pending();
        repeat (80) @(posedge clk);

        $display("Accepted %0d items (%0d with an effect); checked %0d results,",
                 items_accepted, items_effective, results_checked);
        $display("including %0d error answers and %0d empty listings.",
                 error_answers, empty_answers);
        if (failures == 0)
        begin
            $display("list_insert_delete_reverse_tb: clean");
        end
        else
        begin
            $display("list_insert_delete_reverse_tb: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lidr_pkg.sv
rtl/core/lidr_cell.sv
rtl/core/list_insert_delete_reverse.sv
rtl/core/lidr_checker.sv
tb/list_insert_delete_reverse_tb.sv
